@@ src/rrts_pkg.sv @@
// Package for the round-robin task scheduler: sizes, event codes, task states
// and the command/status structs between controller and datapath.
// Depends on nothing.
package rrts_pkg;

  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdBits   = 16;
  localparam int unsigned IdxW     = $clog2(MaxTasks);
  localparam int unsigned CntW     = $clog2(MaxTasks + 1);

  typedef logic [IdBits-1:0] id_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [CntW-1:0]   cnt_t;

  localparam logic [3:0] EvAdmitted = 4'd0;
  localparam logic [3:0] EvRefused  = 4'd1;
  localparam logic [3:0] EvRotated  = 4'd2;
  localparam logic [3:0] EvFinished = 4'd3;
  localparam logic [3:0] EvSlept    = 4'd4;
  localparam logic [3:0] EvBlocked  = 4'd5;
  localparam logic [3:0] EvReleased = 4'd6;
  localparam logic [3:0] EvWoken    = 4'd7;
  localparam logic [3:0] EvEmpty    = 4'd8;

  localparam logic [1:0] StRun   = 2'd0;
  localparam logic [1:0] StTerm  = 2'd1;
  localparam logic [1:0] StSleep = 2'd2;
  localparam logic [1:0] StWait  = 2'd3;

  localparam logic FuncAdmit = 1'b0;

  typedef enum logic [3:0] {
    CmdNone,
    CmdLatch,     // capture input request
    CmdAdmit,     // admit new id
    CmdPop,       // pop run queue head into current id
    CmdRotate,    // push current id back
    CmdBlkStep,   // examine blocked entry at scan index
    CmdBlkDone,   // commit compacted blocked count
    CmdBlock,     // append current to blocked list
    CmdSlpScan,   // examine sleep entry at scan index (insert search)
    CmdSlpShift,  // shift sleep entry up by one
    CmdSlpPut,    // write insert slot
    CmdWake,      // wake front sleeper at scan index
    CmdWakeDone   // compact sleep list by wake count
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic func;
    logic [1:0] state;
    logic refuse;       // admit not possible
    logic rq_empty;
    logic scan_end;     // scan index reached blocked count
    logic blk_hit;      // blocked entry matches current id
    logic blk_any;      // an entry at or after the scan index waits on current id
    logic blk_more;     // an entry after the scan index waits on current id
    logic slp_stop;     // insert position found
    logic shift_end;    // shift pointer reached insert position
    logic wake_due;     // front-of-remaining sleeper is due
    logic wake_next;    // the sleeper after it is due too
    logic front_due;    // first sleeper of the list is due
    logic self_due;     // current task's own wake tick is due
    logic wake_fin;     // sleep list compaction complete
  } dp_sts_t;

endpackage

@@ src/rrts_if.sv @@
// Valid/ready channel interfaces for the scheduler's request and event ports.
// Depends on nothing.
interface rrts_req_if;
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [1:0]            task_state;
  logic [31:0]           wake_tick;
  logic [15:0]           wait_pid;
  logic [31:0]           now;
  modport source (output valid, func, task_state, wake_tick, wait_pid, now, input ready);
  modport sink   (input valid, func, task_state, wake_tick, wait_pid, now, output ready);
endinterface

interface rrts_evt_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [15:0] pid;
  logic        last;
  modport source (output valid, event_res, pid, last, input ready);
  modport sink   (input valid, event_res, pid, last, output ready);
endinterface

@@ src/rrts_datapath.sv @@
// Datapath of the scheduler: run queue, sleep list, blocked list, id counter.
// Depends on rrts_pkg; driven by rrts_ctrl through command structs.
module rrts_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrts_pkg::dp_cmd_t  cmd_i,
  input  logic               func_i,
  input  logic [1:0]         task_state_i,
  input  logic [31:0]        wake_tick_i,
  input  logic [15:0]        wait_pid_i,
  input  logic [31:0]        now_i,
  output rrts_pkg::dp_sts_t  sts_o,
  output logic [15:0]        evt_pid_o
);
  import rrts_pkg::*;

  id_t         rq_mem [MaxTasks];
  id_t         slp_id [MaxTasks];
  logic [31:0] slp_due [MaxTasks];
  id_t         blk_id [MaxTasks];
  id_t         blk_on [MaxTasks];

  idx_t rq_head_q;
  cnt_t rq_cnt_q, slp_cnt_q, blk_cnt_q;
  id_t  last_id_q;

  logic        func_q;
  logic [1:0]  state_q;
  logic [31:0] wake_q, now_q;
  id_t         wpid_q;
  id_t         cur_q;
  cnt_t        scan_q;  // scan index
  cnt_t        keep_q;  // compaction write index / insert position
  cnt_t        shp_q;   // shift pointer
  id_t         pid_q;

  logic [IdxW:0] tail_sum;
  idx_t          tail;
  idx_t          scan_ix, keep_ix, shp_ix, shm_ix;
  logic [CntW+1:0] total;
  cnt_t          wk_src;
  cnt_t          nxt;
  idx_t          nxt_ix;

  always_comb begin
    tail_sum = {1'b0, rq_head_q} + rq_cnt_q[IdxW:0];
    if (tail_sum >= (IdxW+1)'(MaxTasks)) tail_sum = tail_sum - (IdxW+1)'(MaxTasks);
    tail    = tail_sum[IdxW-1:0];
    scan_ix = scan_q[IdxW-1:0];
    keep_ix = keep_q[IdxW-1:0];
    shp_ix  = shp_q[IdxW-1:0];
    shm_ix  = IdxW'(shp_q - cnt_t'(1));
    wk_src  = scan_q + keep_q;
    nxt     = scan_q + cnt_t'(1);
    nxt_ix  = nxt[IdxW-1:0];
    total   = (CntW+2)'(rq_cnt_q) + (CntW+2)'(slp_cnt_q) + (CntW+2)'(blk_cnt_q);
  end

  always_comb begin
    sts_o.func      = func_q;
    sts_o.state     = state_q;
    sts_o.refuse    = (total >= (CntW+2)'(MaxTasks)) || (last_id_q == '1);
    sts_o.rq_empty  = (rq_cnt_q == '0);
    sts_o.scan_end  = (scan_q == blk_cnt_q);
    sts_o.blk_hit   = (blk_on[scan_ix] == cur_q);
    sts_o.blk_any   = 1'b0;
    sts_o.blk_more  = 1'b0;
    // look ahead for further releases so the last flag is known early
    for (int i = 0; i < MaxTasks; i++) begin
      if ((cnt_t'(i) < blk_cnt_q) && (blk_on[i] == cur_q)) begin
        if (cnt_t'(i) >= scan_q) sts_o.blk_any = 1'b1;
        if (cnt_t'(i) > scan_q)  sts_o.blk_more = 1'b1;
      end
    end
    sts_o.slp_stop  = (scan_q == slp_cnt_q) || (slp_due[scan_ix] > wake_q);
    sts_o.shift_end = (shp_q == keep_q);
    // wake scan: scan_q counts woken entries; they sit at the list front
    sts_o.wake_due  = (scan_q != slp_cnt_q) && (slp_due[scan_ix] <= now_q);
    sts_o.wake_next = (nxt < slp_cnt_q) && (slp_due[nxt_ix] <= now_q);
    sts_o.front_due = (slp_cnt_q != '0) && (slp_due[0] <= now_q);
    sts_o.self_due  = (wake_q <= now_q);
    sts_o.wake_fin  = (scan_q == '0) || (wk_src >= slp_cnt_q);
  end

  assign evt_pid_o = pid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_head_q <= '0;
      rq_cnt_q  <= '0;
      slp_cnt_q <= '0;
      blk_cnt_q <= '0;
      last_id_q <= '0;
      scan_q    <= '0;
      keep_q    <= '0;
      shp_q     <= '0;
    end else begin
      case (cmd_i.cmd)
        CmdLatch: begin
          scan_q <= '0;
          keep_q <= '0;
        end
        CmdAdmit: begin
          last_id_q    <= last_id_q + id_t'(1);
          rq_mem[tail] <= last_id_q + id_t'(1);
          rq_cnt_q     <= rq_cnt_q + cnt_t'(1);
        end
        CmdPop: begin
          rq_head_q <= rq_head_q + idx_t'(1);
          rq_cnt_q  <= rq_cnt_q - cnt_t'(1);
        end
        CmdRotate: begin
          rq_mem[tail] <= cur_q;
          rq_cnt_q     <= rq_cnt_q + cnt_t'(1);
        end
        CmdBlkStep: begin
          if (blk_on[scan_ix] == cur_q) begin
            rq_mem[tail] <= blk_id[scan_ix];
            rq_cnt_q     <= rq_cnt_q + cnt_t'(1);
          end else begin
            blk_id[keep_ix] <= blk_id[scan_ix];
            blk_on[keep_ix] <= blk_on[scan_ix];
            keep_q          <= keep_q + cnt_t'(1);
          end
          scan_q <= scan_q + cnt_t'(1);
        end
        CmdBlkDone: begin
          blk_cnt_q <= keep_q;
          scan_q    <= '0;
          keep_q    <= '0;
        end
        CmdBlock: begin
          if (blk_cnt_q != cnt_t'(MaxTasks)) begin
            blk_id[blk_cnt_q[IdxW-1:0]] <= cur_q;
            blk_on[blk_cnt_q[IdxW-1:0]] <= wpid_q;
            blk_cnt_q <= blk_cnt_q + cnt_t'(1);
          end
        end
        CmdSlpScan: begin
          if (sts_o.slp_stop) begin
            keep_q <= scan_q;
            shp_q  <= slp_cnt_q;
          end else begin
            scan_q <= scan_q + cnt_t'(1);
          end
        end
        CmdSlpShift: begin
          slp_id[shp_ix]  <= slp_id[shm_ix];
          slp_due[shp_ix] <= slp_due[shm_ix];
          shp_q           <= shp_q - cnt_t'(1);
        end
        CmdSlpPut: begin
          if (slp_cnt_q != cnt_t'(MaxTasks)) begin
            slp_id[keep_ix]  <= cur_q;
            slp_due[keep_ix] <= wake_q;
            slp_cnt_q        <= slp_cnt_q + cnt_t'(1);
          end
          scan_q <= '0;
          keep_q <= '0;
        end
        CmdWake: begin
          rq_mem[tail] <= slp_id[scan_ix];
          rq_cnt_q     <= rq_cnt_q + cnt_t'(1);
          scan_q       <= scan_q + cnt_t'(1);
        end
        CmdWakeDone: begin
          // move remaining entries down by the wake count, one a cycle
          if (sts_o.wake_fin) begin
            slp_cnt_q <= slp_cnt_q - scan_q;
            scan_q    <= '0;
            keep_q    <= '0;
          end else begin
            slp_id[keep_ix]  <= slp_id[wk_src[IdxW-1:0]];
            slp_due[keep_ix] <= slp_due[wk_src[IdxW-1:0]];
            keep_q           <= keep_q + cnt_t'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      CmdLatch: begin
        func_q  <= func_i;
        state_q <= task_state_i;
        wake_q  <= wake_tick_i;
        wpid_q  <= wait_pid_i;
        now_q   <= now_i;
        pid_q   <= '0;
      end
      CmdAdmit:   pid_q <= last_id_q + id_t'(1);
      CmdPop: begin
        cur_q <= rq_mem[rq_head_q];
        pid_q <= rq_mem[rq_head_q];
      end
      // hold the pid of a waiting event while non-matching entries pass
      CmdBlkStep: if (blk_on[scan_ix] == cur_q) pid_q <= blk_id[scan_ix];
      CmdWake:    pid_q <= slp_id[scan_ix];
      default: ;
    endcase
  end

endmodule

@@ src/rrts_ctrl.sv @@
// Controller of the scheduler: sequences datapath commands and the event port.
// Depends on rrts_pkg.
module rrts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               evt_valid_o,
  input  logic               evt_ready_i,
  output logic [3:0]         evt_res_o,
  output logic               evt_last_o,
  output rrts_pkg::dp_cmd_t  cmd_o,
  input  rrts_pkg::dp_sts_t  sts_i
);
  import rrts_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SDecode, SPop, SAct, SBlk, SSlpScan, SSlpShift, SWake, SWakeDone,
    SEmit
  } state_e;

  state_e state_q, ret_q;
  logic       ev_valid_q, ev_last_q;
  logic [3:0] ev_res_q;
  logic       emit_free;

  // After emitting, continue in ret_q. Events are staged in the datapath pid.
  assign emit_free   = !ev_valid_q || evt_ready_i;
  assign req_ready_o = (state_q == SIdle) && emit_free;
  assign evt_valid_o = ev_valid_q;
  assign evt_res_o   = ev_res_q;
  assign evt_last_o  = ev_last_q;

  always_comb begin
    cmd_o.cmd = CmdNone;
    case (state_q)
      SIdle:   if (req_valid_i && req_ready_o) cmd_o.cmd = CmdLatch;
      SDecode: if (emit_free) begin
        if (sts_i.func == FuncAdmit) cmd_o.cmd = sts_i.refuse ? CmdNone : CmdAdmit;
        else if (!sts_i.rq_empty) cmd_o.cmd = CmdPop;
      end
      SAct: if (emit_free) begin
        case (sts_i.state)
          StRun:   cmd_o.cmd = CmdRotate;
          StWait:  cmd_o.cmd = CmdBlock;
          StSleep: cmd_o.cmd = CmdSlpScan;
          default: cmd_o.cmd = CmdNone;
        endcase
      end
      SBlk: begin
        if (sts_i.scan_end) cmd_o.cmd = CmdBlkDone;
        else if (!sts_i.blk_hit || emit_free) cmd_o.cmd = CmdBlkStep;
      end
      SSlpScan:  cmd_o.cmd = CmdSlpScan;
      SSlpShift: cmd_o.cmd = sts_i.shift_end ? CmdSlpPut : CmdSlpShift;
      SWake:     if (sts_i.wake_due && emit_free) cmd_o.cmd = CmdWake;
      SWakeDone: cmd_o.cmd = CmdWakeDone;
      default: cmd_o.cmd = CmdNone;
    endcase
  end

  // SEmit: the pid register holds the current event payload before it is
  // presented; the output valid is registered from SEmit, after the command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      ret_q      <= SIdle;
      ev_valid_q <= 1'b0;
      ev_last_q  <= 1'b0;
      ev_res_q   <= EvAdmitted;
    end else begin
      if (state_q == SEmit) ev_valid_q <= 1'b1;
      else if (ev_valid_q && evt_ready_i) ev_valid_q <= 1'b0;
      case (state_q)
        SIdle: if (req_valid_i && req_ready_o) state_q <= SDecode;
        SDecode: if (emit_free) begin
          if (sts_i.func == FuncAdmit) begin
            ev_res_q <= sts_i.refuse ? EvRefused : EvAdmitted;
            ev_last_q <= 1'b1;
            state_q  <= SEmit;
            ret_q    <= SIdle;
          end else if (sts_i.rq_empty) begin
            ev_res_q <= EvEmpty;
            ev_last_q <= !sts_i.front_due;
            state_q  <= SEmit;
            ret_q    <= SWake;
          end else begin
            state_q <= SAct;
          end
        end
        SAct: if (emit_free) begin
          state_q   <= SEmit;
          case (sts_i.state)
            StRun: begin
              ev_res_q  <= EvRotated;
              ev_last_q <= !sts_i.front_due;
              ret_q     <= SWake;
            end
            StTerm: begin
              ev_res_q  <= EvFinished;
              ev_last_q <= !(sts_i.blk_any || sts_i.front_due);
              ret_q     <= SBlk;
            end
            StSleep: begin
              // the inserted task may itself be due right away
              ev_res_q  <= EvSlept;
              ev_last_q <= !(sts_i.front_due || sts_i.self_due);
              ret_q     <= SSlpScan;
            end
            default: begin
              ev_res_q  <= EvBlocked;
              ev_last_q <= !sts_i.front_due;
              ret_q     <= SWake;
            end
          endcase
        end
        SBlk: begin
          if (sts_i.scan_end) state_q <= SWake;
          else if (sts_i.blk_hit && emit_free) begin
            ev_res_q  <= EvReleased;
            ev_last_q <= !(sts_i.blk_more || sts_i.front_due);
            state_q   <= SEmit;
            ret_q     <= SBlk;
          end
        end
        SSlpScan:  if (sts_i.slp_stop) state_q <= SSlpShift;
        SSlpShift: if (sts_i.shift_end) state_q <= SWake;
        SWake: begin
          if (sts_i.wake_due) begin
            if (emit_free) begin
              ev_res_q  <= EvWoken;
              ev_last_q <= !sts_i.wake_next;
              state_q   <= SEmit;
              ret_q     <= SWake;
            end
          end else begin
            state_q <= SWakeDone;
          end
        end
        SWakeDone: if (sts_i.wake_fin) state_q <= SIdle;
        SEmit: begin
          // pid is now settled; present the event
          state_q    <= ret_q;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

@@ src/round_robin_task_scheduler_unit.sv @@
// Round-robin task scheduler with run queue, sleep list and blocked list.
//
// Channels: req (sink) carries func, task_state, wake_tick, wait_pid, now;
// evt (source) carries event_res, pid, last. Both are valid/ready; a request
// or event moves when valid and ready are high at a rising edge of clk_i.
// Each request yields one to seventeen events; last marks the final one.
// An admit is decoded and its event staged through SEmit before it is valid,
// and the next request can go once that event is taken. A reschedule scans
// the blocked entries and issues each release, searches and shifts the sleep
// entries and writes the insert, issues each woken task and then moves each
// remaining sleeper down over the sixteen-entry lists. One request is handled
// at a time; req ready is high only in idle once the previous event is taken
// or is taken in that cycle.
// A stalled event receiver holds the event register and halts the sequencer where it would issue its next event.
// rst_ni clears all queues and the id counter; list contents need no clearing.
// The last flag is looked ahead from the lists before each event is issued.
module round_robin_task_scheduler_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  rrts_req_if.sink  req,
  rrts_evt_if.source evt
);
  import rrts_pkg::*;

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [15:0] dp_pid;
  logic [3:0]  res;
  logic        lst_raw;
  logic        valid;

  rrts_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .func_i(req.func), .task_state_i(req.task_state), .wake_tick_i(req.wake_tick),
    .wait_pid_i(req.wait_pid), .now_i(req.now),
    .sts_o(sts), .evt_pid_o(dp_pid)
  );

  rrts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(req.valid), .req_ready_o(req.ready),
    .evt_valid_o(valid), .evt_ready_i(evt.ready),
    .evt_res_o(res), .evt_last_o(lst_raw),
    .cmd_o(cmd), .sts_i(sts)
  );

  // Event fields come straight from controller and datapath registers.
  assign evt.valid     = valid;
  assign evt.event_res = res;
  assign evt.pid       = dp_pid;
  assign evt.last      = lst_raw;

endmodule

@@ sim/round_robin_task_scheduler_unit_tb.sv @@
// Testbench for round_robin_task_scheduler_unit: drives random and directed
// requests, predicts the event stream and compares every event field.
// Depends on rrts_pkg, rrts_if.sv and the scheduler RTL.
`timescale 1ns / 1ps

module round_robin_task_scheduler_unit_tb;
  import rrts_pkg::*;

  typedef struct packed {
    logic [3:0]  ev;
    logic [15:0] pid;
    logic        last;
  } sched_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rrts_req_if req ();
  rrts_evt_if evt ();

  round_robin_task_scheduler_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .evt   (evt.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] run_q[$];
  logic [15:0] sleep_pid[$];
  logic [31:0] sleep_tick[$];
  logic [15:0] blk_pid[$];
  logic [15:0] blk_on[$];
  logic [15:0] next_id;
  sched_event_t pending_events[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;

  task automatic push_event(input logic [3:0] ev, input logic [15:0] pid);
    sched_event_t e;
    e.ev = ev;
    e.pid = pid;
    e.last = 1'b0;
    pending_events.insert(pending_events.size(), e);
  endtask

  task automatic predict_schedule(input logic func, input logic [1:0] st,
                                  input logic [31:0] wake, input logic [15:0] wpid,
                                  input logic [31:0] tick_now);
    logic [15:0] cur;
    int pos;
    logic [15:0] keep_pid[$];
    logic [15:0] keep_on[$];
    if (func == FuncAdmit) begin
      if (run_q.size() + sleep_pid.size() + blk_pid.size() >= MaxTasks ||
          next_id == 16'hFFFF) begin
        push_event(EvRefused, 16'd0);
      end else begin
        next_id++;
        run_q.insert(run_q.size(), next_id);
        push_event(EvAdmitted, next_id);
      end
    end else begin
      if (run_q.size() == 0) begin
        push_event(EvEmpty, 16'd0);
      end else begin
        cur = run_q[0];
        run_q.delete(0);
        case (st)
          StRun: begin
            run_q.insert(run_q.size(), cur);
            push_event(EvRotated, cur);
          end
          StTerm: begin
            push_event(EvFinished, cur);
            for (int i = 0; i < blk_pid.size(); i++) begin
              if (blk_on[i] == cur) begin
                run_q.insert(run_q.size(), blk_pid[i]);
                push_event(EvReleased, blk_pid[i]);
              end else begin
                keep_pid.insert(keep_pid.size(), blk_pid[i]);
                keep_on.insert(keep_on.size(), blk_on[i]);
              end
            end
            blk_pid = keep_pid;
            blk_on = keep_on;
          end
          StSleep: begin
            pos = 0;
            while (pos < sleep_tick.size() && sleep_tick[pos] <= wake) pos++;
            sleep_pid.insert(pos, cur);
            sleep_tick.insert(pos, wake);
            push_event(EvSlept, cur);
          end
          default: begin
            blk_pid.insert(blk_pid.size(), cur);
            blk_on.insert(blk_on.size(), wpid);
            push_event(EvBlocked, cur);
          end
        endcase
      end
      // wake every due sleeper from the front
      while (sleep_tick.size() > 0 && sleep_tick[0] <= tick_now) begin
        cur = sleep_pid[0];
        sleep_pid.delete(0);
        sleep_tick.delete(0);
        run_q.insert(run_q.size(), cur);
        push_event(EvWoken, cur);
      end
    end
    pending_events[pending_events.size() - 1].last = 1'b1;
  endtask

  task automatic send_request(input logic func, input logic [1:0] st,
                              input logic [31:0] wake, input logic [15:0] wpid,
                              input logic [31:0] tick_now);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.func <= func;
    req.task_state <= st;
    req.wake_tick <= wake;
    req.wait_pid <= wpid;
    req.now <= tick_now;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predict_schedule(func, st, wake, wpid, tick_now);
  endtask

  // receiver stalls and event check
  always @(posedge clk_i) begin
    sched_event_t want;
    if (rst_ni) begin
      if (evt.valid && evt.ready) begin
        if (pending_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected event ev=%0d pid=%0d last=%0b",
                     evt.event_res, evt.pid, evt.last);
        end else begin
          want = pending_events[0];
          pending_events.delete(0);
          if (evt.event_res !== want.ev || evt.pid !== want.pid ||
              evt.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("event mismatch: exp ev=%0d pid=%0d last=%0b, %s%0d pid=%0d last=%0b",
                       want.ev, want.pid, want.last, "got ev=",
                       evt.event_res, evt.pid, evt.last);
          end
        end
      end
      evt.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // random request with mostly sensible content; ticks kept small for many wakes
  task automatic random_request(input int admit_pct);
    logic func;
    logic [31:0] tick_now;
    logic [31:0] wake;
    logic [15:0] wpid;
    func = ($urandom_range(99, 0) < admit_pct) ? FuncAdmit : ~FuncAdmit;
    tick_now = ($urandom_range(9, 0) == 0) ? $urandom() : $urandom_range(40, 0);
    wake = ($urandom_range(9, 0) == 0) ? $urandom() : $urandom_range(60, 0);
    wpid = ($urandom_range(4, 0) == 0) ? 16'($urandom()) :
           16'($urandom_range(int'(next_id) + 1, 0));
    send_request(func, 2'($urandom_range(3, 0)), wake, wpid, tick_now);
  endtask

  task automatic test_directed();
    send_request(~FuncAdmit, StRun, 32'd0, 16'd0, 32'd0);  // empty run queue
    for (int i = 0; i < 17; i++)  // fill every slot, then refuse
      send_request(FuncAdmit, StRun, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(~FuncAdmit, StRun, 32'd0, 16'd0, 32'd0);
    send_request(~FuncAdmit, StWait, 32'd0, 16'd4, 32'd0);
    send_request(~FuncAdmit, StWait, 32'd0, 16'd4, 32'd0);
    send_request(~FuncAdmit, StWait, 32'd0, 16'hFFFF, 32'd0);  // never-existing id
    send_request(~FuncAdmit, StSleep, 32'hFFFF_FFFF, 16'd0, 32'd0);
    send_request(~FuncAdmit, StSleep, 32'd5, 16'd0, 32'd0);
    send_request(~FuncAdmit, StSleep, 32'd5, 16'd0, 32'd0);  // tie keeps order
    send_request(~FuncAdmit, StTerm, 32'd0, 16'd0, 32'd9);   // finish and wake
    send_request(~FuncAdmit, StRun, 32'd0, 16'd0, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) random_request(30);
    wait_drained();
  endtask

  initial begin
    req.valid = 1'b0;
    req.func = 1'b0;
    req.task_state = 2'd0;
    req.wake_tick = 32'd0;
    req.wait_pid = 16'd0;
    req.now = 32'd0;
    evt.ready = 1'b0;
    next_id = 16'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 70);
    test_random_phase(82, 0, 70);
    test_random_phase(0, 82, 70);
    test_random_phase(22, 22, 70);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
src/rrts_pkg.sv
src/rrts_if.sv
src/rrts_datapath.sv
src/rrts_ctrl.sv
src/round_robin_task_scheduler_unit.sv
sim/round_robin_task_scheduler_unit_tb.sv
